// ----- rtl/opd_pkg.sv -----
// shared types and constants of the oversampled preamble deframer
package opd_pkg;

  localparam int CfgAddrBits = 1;
  localparam int CfgDataBits = 16;
  localparam int SpsBits     = 8;
  localparam int PatternBits = 16;
  localparam int IndexBits   = 7;
  localparam int InDataBits  = 8;
  localparam int OutDataBits = 16;

  localparam logic [CfgAddrBits-1:0] REG_SPS     = 1'd0;
  localparam logic [CfgAddrBits-1:0] REG_PATTERN = 1'd1;

  localparam logic [SpsBits-1:0]     SPS_RESET     = 8'd20;
  localparam logic [SpsBits-1:0]     SPS_MIN       = 8'd2;
  localparam logic [PatternBits-1:0] PATTERN_RESET = 16'h5555;

  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic sym;
    logic has_run;
    logic wend;
  } job_flags_t;

  localparam int JobFlagBits = $bits(job_flags_t);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_CAPTURE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_SYMS,
    BK_STATUS
  } back_state_t;

endpackage

// ----- rtl/opd_front.sv -----
// front end: sample run-length measurement, jobs per transition or window end
module opd_front #(
  parameter int RUN_COUNTER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        sample_bit,
  input  logic                        window_end,
  output logic                        job_push,
  output opd_pkg::job_flags_t         job_flags,
  output logic [RUN_COUNTER_BITS-1:0] job_run
);

  logic                        started_r, started_nxt;
  logic                        prev_r, prev_nxt;
  logic [RUN_COUNTER_BITS-1:0] run_r, run_nxt;
  logic                        transition;

  assign transition = started_r && (sample_bit != prev_r);

  always_comb begin
    started_nxt = started_r;
    prev_nxt    = prev_r;
    run_nxt     = run_r;
    if (accept) begin
      if (!started_r || transition) begin
        started_nxt = 1'b1;
        prev_nxt    = sample_bit;
        run_nxt     = RUN_COUNTER_BITS'(1);
      end else if (run_r != {RUN_COUNTER_BITS{1'b1}}) begin
        run_nxt = run_r + RUN_COUNTER_BITS'(1);
      end
      if (window_end) begin
        started_nxt = 1'b0;
        prev_nxt    = 1'b0;
        run_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      prev_r    <= 1'b0;
      run_r     <= '0;
    end else begin
      started_r <= started_nxt;
      prev_r    <= prev_nxt;
      run_r     <= run_nxt;
    end
  end

  assign job_push          = accept && (transition || window_end);
  assign job_flags.sym     = prev_r;
  assign job_flags.has_run = transition;
  assign job_flags.wend    = window_end;
  assign job_run           = run_r;

endmodule

// ----- rtl/opd_fifo.sv -----
// small register queue between front and back
module opd_fifo #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_r [DEPTH];
  logic [PtrBits-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrBits-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntBits-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CntBits'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntBits'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/opd_back.sv -----
// back end: run to symbol conversion, preamble match, code capture and result register
module opd_back #(
  parameter int PREAMBLE_BITS       = 16,
  parameter int CODE_BITS           = 128,
  parameter int MAX_SYMBOLS_PER_RUN = 16,
  parameter int RUN_COUNTER_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [opd_pkg::SpsBits-1:0]      sps,
  input  logic [PREAMBLE_BITS-1:0]         pattern,
  input  logic                             job_valid,
  input  opd_pkg::job_flags_t              job_flags,
  input  logic [RUN_COUNTER_BITS-1:0]      job_run,
  output logic                             job_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_kind,
  output logic                             out_bit,
  output logic [opd_pkg::IndexBits-1:0]    out_index,
  output logic                             out_found,
  output logic                             out_last
);

  localparam int RemBits  = RUN_COUNTER_BITS + 2;
  localparam int SymBits  = $clog2(MAX_SYMBOLS_PER_RUN + 1);
  localparam int FillBits = $clog2(PREAMBLE_BITS + 1);
  localparam int CapBits  = $clog2(CODE_BITS + 1);
  localparam int IdxExt   = (CapBits > opd_pkg::IndexBits) ? CapBits : opd_pkg::IndexBits;

  opd_pkg::back_state_t    state_r, state_nxt;
  opd_pkg::phase_t         phase_r;
  logic [PREAMBLE_BITS-1:0] hist_r;
  logic [PREAMBLE_BITS:0]   hist_shift;
  logic [FillBits-1:0]      fill_r;
  logic [FillBits-1:0]      fill_inc;
  logic [CapBits-1:0]       cap_r;
  logic [IdxExt-1:0]        cap_ext;

  logic               sym_r;
  logic               wend_r;
  logic [RemBits-1:0] rem_r;
  logic [SymBits-1:0] cnt_r;

  logic [RemBits-1:0] two_sps;
  logic [RemBits-1:0] four_sps;
  logic               go;
  logic               more;
  logic               produce;
  logic               slot_free;
  logic               step;
  logic               emit_sym;
  logic               emit_stat;
  logic               sym_last;

  logic                            out_valid_r;
  logic                            out_kind_r;
  logic                            out_bit_r;
  logic [opd_pkg::IndexBits-1:0]   out_index_r;
  logic                            out_found_r;
  logic                            out_last_r;

  assign two_sps   = RemBits'({sps, 1'b0});
  assign four_sps  = RemBits'({sps, 2'b00});
  assign go        = (rem_r >= two_sps) && (cnt_r < SymBits'(MAX_SYMBOLS_PER_RUN));
  assign more      = (rem_r >= four_sps) &&
                     (SymBits'(cnt_r + SymBits'(1)) < SymBits'(MAX_SYMBOLS_PER_RUN));
  assign produce   = (phase_r == opd_pkg::PH_CAPTURE);
  assign slot_free = !out_valid_r || out_ready;
  assign sym_last  = !wend_r && (!more || (cap_r == CapBits'(CODE_BITS - 1)));
  assign hist_shift = {hist_r, sym_r};
  assign fill_inc  = (fill_r == FillBits'(PREAMBLE_BITS)) ? fill_r : fill_r + FillBits'(1);
  assign cap_ext   = IdxExt'(cap_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      opd_pkg::BK_LOAD: begin
        if (job_valid) begin
          state_nxt = job_flags.has_run ? opd_pkg::BK_SYMS : opd_pkg::BK_STATUS;
        end
      end
      opd_pkg::BK_SYMS: begin
        if (!go) begin
          state_nxt = wend_r ? opd_pkg::BK_STATUS : opd_pkg::BK_LOAD;
        end
      end
      opd_pkg::BK_STATUS: begin
        if (slot_free) begin
          state_nxt = opd_pkg::BK_LOAD;
        end
      end
      default: state_nxt = opd_pkg::BK_LOAD;
    endcase
  end

  always_comb begin
    job_pop   = 1'b0;
    step      = 1'b0;
    emit_sym  = 1'b0;
    emit_stat = 1'b0;
    case (state_r)
      opd_pkg::BK_LOAD:   job_pop = job_valid;
      opd_pkg::BK_SYMS: begin
        step     = go && (!produce || slot_free);
        emit_sym = go && produce && slot_free;
      end
      opd_pkg::BK_STATUS: emit_stat = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= opd_pkg::BK_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // job registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      sym_r  <= job_flags.sym;
      wend_r <= job_flags.wend;
      rem_r  <= RemBits'({job_run, 1'b0}) + RemBits'(sps);
      cnt_r  <= '0;
    end else if (step) begin
      rem_r <= rem_r - two_sps;
      cnt_r <= cnt_r + SymBits'(1);
    end
  end

  // preamble matcher and code capture
  always_ff @(posedge clk) begin
    if (!rst_n || emit_stat) begin
      phase_r <= opd_pkg::PH_SEARCH;
      hist_r  <= '0;
      fill_r  <= '0;
      cap_r   <= '0;
    end else if (step) begin
      case (phase_r)
        opd_pkg::PH_SEARCH: begin
          hist_r <= hist_shift[PREAMBLE_BITS-1:0];
          fill_r <= fill_inc;
          if ((fill_inc == FillBits'(PREAMBLE_BITS)) &&
              (hist_shift[PREAMBLE_BITS-1:0] == pattern)) begin
            phase_r <= opd_pkg::PH_CAPTURE;
            cap_r   <= '0;
          end
        end
        opd_pkg::PH_CAPTURE: begin
          cap_r <= cap_r + CapBits'(1);
          if (cap_r == CapBits'(CODE_BITS - 1)) begin
            phase_r <= opd_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_sym || emit_stat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sym) begin
      out_kind_r  <= opd_pkg::KIND_SYMBOL;
      out_bit_r   <= sym_r;
      out_index_r <= cap_ext[opd_pkg::IndexBits-1:0];
      out_found_r <= 1'b0;
      out_last_r  <= sym_last;
    end else if (emit_stat) begin
      out_kind_r  <= opd_pkg::KIND_STATUS;
      out_bit_r   <= 1'b0;
      out_index_r <= '0;
      out_found_r <= (phase_r == opd_pkg::PH_DONE);
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_bit   = out_bit_r;
  assign out_index = out_index_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/oversampled_preamble_deframer_unit.sv -----
// top level of the oversampled preamble deframer
// Takes one sample bit per beat and turns each finished run of equal samples into
// round(run / samples_per_symbol) symbols, capped per run; symbols feed a preamble
// matcher and the CODE_BITS symbols after the first match come out with their index,
// followed at window end by a status beat. The front end measures runs and takes one
// sample per cycle as long as the job queue (FIFO_DEPTH entries) has room. The back
// end loads each run, then decodes its symbols one by one (one subtract and compare
// of the shared remainder each), closes the run and, for a window-end job, sends the
// status beat; samples stall only when the job queue fills because transitions come
// faster than the back end drains them or the result side holds off. A window-end
// sample without a transition queues a status-only job.
module oversampled_preamble_deframer_unit #(
  parameter int PREAMBLE_BITS       = 16,
  parameter int CODE_BITS           = 128,
  parameter int MAX_SYMBOLS_PER_RUN = 16,
  parameter int RUN_COUNTER_BITS    = 16,
  parameter int FIFO_DEPTH          = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [opd_pkg::InDataBits-1:0]     in_tdata,   // sample_bit
  input  logic                               in_tlast,   // window_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [opd_pkg::OutDataBits-1:0]    out_tdata,  // code_bit, code_index, code_done
  output logic                               out_tuser,  // result_kind
  output logic                               out_tlast,  // last_of_run
  input  logic                               cfg_we,
  input  logic [opd_pkg::CfgAddrBits-1:0]    cfg_addr,
  input  logic [opd_pkg::CfgDataBits-1:0]    cfg_wdata
);

  localparam int JobBits = opd_pkg::JobFlagBits + RUN_COUNTER_BITS;

  logic [opd_pkg::SpsBits-1:0]     sps_r;
  logic [opd_pkg::PatternBits-1:0] pattern_r;
  logic [opd_pkg::SpsBits-1:0]     sps_eff;
  logic [PREAMBLE_BITS-1:0]        pattern_ext;

  logic                        accept;
  logic                        fifo_full;
  logic                        job_push;
  opd_pkg::job_flags_t         push_flags;
  logic [RUN_COUNTER_BITS-1:0] push_run;
  logic [JobBits-1:0]          push_data;
  logic [JobBits-1:0]          pop_data;
  logic                        job_valid;
  logic                        job_pop;
  opd_pkg::job_flags_t         pop_flags;
  logic [RUN_COUNTER_BITS-1:0] pop_run;

  logic                            code_bit;
  logic [opd_pkg::IndexBits-1:0]   code_index;
  logic                            code_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r     <= opd_pkg::SPS_RESET;
      pattern_r <= opd_pkg::PATTERN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        opd_pkg::REG_SPS:     sps_r     <= cfg_wdata[opd_pkg::SpsBits-1:0];
        opd_pkg::REG_PATTERN: pattern_r <= cfg_wdata[opd_pkg::PatternBits-1:0];
        default: ;
      endcase
    end
  end

  assign sps_eff     = (sps_r < opd_pkg::SPS_MIN) ? opd_pkg::SPS_MIN : sps_r;
  assign pattern_ext = PREAMBLE_BITS'(pattern_r);

  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && !fifo_full;

  opd_front #(
    .RUN_COUNTER_BITS (RUN_COUNTER_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample_bit (in_tdata[0]),
    .window_end (in_tlast),
    .job_push   (job_push),
    .job_flags  (push_flags),
    .job_run    (push_run)
  );

  assign push_data = {push_flags, push_run};

  opd_fifo #(
    .WIDTH (JobBits),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (job_pop),
    .pop_data  (pop_data),
    .not_empty (job_valid)
  );

  assign pop_flags = pop_data[JobBits-1:RUN_COUNTER_BITS];
  assign pop_run   = pop_data[RUN_COUNTER_BITS-1:0];

  opd_back #(
    .PREAMBLE_BITS       (PREAMBLE_BITS),
    .CODE_BITS           (CODE_BITS),
    .MAX_SYMBOLS_PER_RUN (MAX_SYMBOLS_PER_RUN),
    .RUN_COUNTER_BITS    (RUN_COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sps       (sps_eff),
    .pattern   (pattern_ext),
    .job_valid (job_valid),
    .job_flags (pop_flags),
    .job_run   (pop_run),
    .job_pop   (job_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_bit   (code_bit),
    .out_index (code_index),
    .out_found (code_done),
    .out_last  (out_tlast)
  );

  assign out_tdata = opd_pkg::OutDataBits'({code_done, code_index, code_bit});

endmodule
